### design/wls_pkg.sv
// Shared types and constants of the warp lane shuffle unit.
`default_nettype none
package wls_pkg;

   localparam int WARP_LANES = 32;
   localparam int LANE_W = 5;
   localparam int VALUE_W = 32;
   localparam int STORE_DEPTH = 1 << LANE_W;
   localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(WARP_LANES - 1);
   localparam logic [LANE_W:0] LANE_LIMIT = (LANE_W + 1)'(WARP_LANES);

   typedef struct packed {
      logic [VALUE_W-1:0] source_value;
      logic               lane_active;
      logic               lane_enabled;
      logic [LANE_W-1:0]  src_lane_sel;
      logic [LANE_W-1:0]  group_mask;
      logic [LANE_W-1:0]  clamp_value;
      logic               butterfly_mode;
   } req_data_type;

   typedef struct packed {
      logic [LANE_W-1:0]  lane_number;
      logic [VALUE_W-1:0] result_value;
      logic               source_valid;
      logic               write_enable;
      logic               last_result;
   } rsp_data_type;

   typedef struct packed {
      logic write_en;
      logic step;
   } dp_cmd_type;

   typedef struct packed {
      logic at_last;
   } dp_status_type;

endpackage
`default_nettype wire

### design/warp_lane_shuffle_unit.sv
// Top level of the warp lane shuffle unit.
// Loads one request per lane, then after a read priming state (ST_PREP) emits one
// result per lane at up to one a cycle, holding a result while rsp_ready is low.
// The single read port of the lane value memory sets the emission rate.
// Synchronous active-high reset clears lane flags, shuffle mode and the lane counter.
`default_nettype none
module warp_lane_shuffle_unit (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wls_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output wls_pkg::rsp_data_type rsp_data
);

   wls_pkg::dp_cmd_type    dp_cmd;
   wls_pkg::dp_status_type dp_status;

   wls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   wls_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (dp_cmd),
      .req_data (req_data),
      .status   (dp_status),
      .rsp_data (rsp_data)
   );

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("request and result channels open together");

   a_last_load_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && dp_status.at_last) |=> !req_ready && !rsp_valid)
      else $error("no priming cycle after the final lane request");

   a_last_result_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last_result) |=> !rsp_valid && req_ready)
      else $error("emission did not end after the final lane");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.write_enable) |->
         (rsp_data.result_value == '0) && !rsp_data.source_valid)
      else $error("disabled lane carries data");
`endif

endmodule
`default_nettype wire

### design/wls_ctrl.sv
// Controller state machine: lane loading, read priming and result emission.
`default_nettype none
module wls_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   input  wls_pkg::dp_status_type status,
   output wls_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_PREP = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd.write_en = 1'b0;
      cmd.step     = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready    = 1'b1;
            cmd.write_en = req_valid;
            cmd.step     = req_valid;
            if (req_valid && status.at_last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            cmd.step  = rsp_ready;
            if (rsp_ready && status.at_last) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### design/wls_datapath.sv
// Datapath: per-lane stores, source lane selection and value memory read.
`default_nettype none
module wls_datapath (
   input  wire                    clock,
   input  wire                    reset,
   input  wls_pkg::dp_cmd_type    cmd,
   input  wls_pkg::req_data_type  req_data,
   output wls_pkg::dp_status_type status,
   output wls_pkg::rsp_data_type  rsp_data
);

   logic [wls_pkg::VALUE_W-1:0] value_mem [wls_pkg::STORE_DEPTH];
   logic [wls_pkg::LANE_W-1:0]  sel_ff    [wls_pkg::STORE_DEPTH];
   logic [wls_pkg::LANE_W-1:0]  seg_ff    [wls_pkg::STORE_DEPTH];
   logic [wls_pkg::LANE_W-1:0]  clamp_ff  [wls_pkg::STORE_DEPTH];
   logic [wls_pkg::STORE_DEPTH-1:0] active_ff;
   logic [wls_pkg::STORE_DEPTH-1:0] enable_ff;
   logic                        mode_ff;
   logic [wls_pkg::LANE_W-1:0]  idx_ff;
   logic [wls_pkg::LANE_W-1:0]  idx_in;
   logic [wls_pkg::VALUE_W-1:0] rd_data_ff;
   logic                        valid_ff;
   logic                        valid_in;
   logic                        we_ff;
   logic                        we_in;
   logic [wls_pkg::LANE_W-1:0]  seg;
   logic [wls_pkg::LANE_W-1:0]  lo;
   logic [wls_pkg::LANE_W-1:0]  hi;
   logic [wls_pkg::LANE_W-1:0]  src;
   logic [wls_pkg::LANE_W-1:0]  rd_addr;
   logic                        at_last;

   assign at_last        = (idx_ff == wls_pkg::LAST_LANE);
   assign status.at_last = at_last;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.step) begin
         idx_in = at_last ? '0 : idx_ff + wls_pkg::LANE_W'(1);
      end
      seg = seg_ff[idx_in];
      lo  = idx_in & seg;
      hi  = lo | (clamp_ff[idx_in] & ~seg);
      if (mode_ff) begin
         src = idx_in ^ sel_ff[idx_in];
      end else begin
         src = lo | (sel_ff[idx_in] & ~seg);
      end
      valid_in = (src >= lo) && (src <= hi) && ({1'b0, src} < wls_pkg::LANE_LIMIT) &&
                 active_ff[src];
      rd_addr  = valid_in ? src : idx_in;
      we_in    = active_ff[idx_in] & enable_ff[idx_in];
   end

   always_ff @(posedge clock) begin
      if (cmd.write_en) begin
         value_mem[idx_ff] <= req_data.source_value;
      end
      rd_data_ff <= value_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.write_en) begin
         sel_ff[idx_ff]   <= req_data.src_lane_sel;
         seg_ff[idx_ff]   <= req_data.group_mask;
         clamp_ff[idx_ff] <= req_data.clamp_value;
      end
      valid_ff <= valid_in;
      we_ff    <= we_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         enable_ff <= '0;
         mode_ff   <= 1'b0;
         idx_ff    <= '0;
      end else begin
         if (cmd.write_en) begin
            active_ff[idx_ff] <= req_data.lane_active;
            enable_ff[idx_ff] <= req_data.lane_enabled;
            mode_ff           <= req_data.butterfly_mode;
         end
         idx_ff <= idx_in;
      end
   end

   assign rsp_data.lane_number  = idx_ff;
   assign rsp_data.result_value = we_ff ? rd_data_ff : '0;
   assign rsp_data.source_valid = we_ff & valid_ff;
   assign rsp_data.write_enable = we_ff;
   assign rsp_data.last_result  = at_last;

endmodule
`default_nettype wire
